[design/tcc_pkg.sv]
// Shared constants, types and the cell index function of the text console.
package tcc_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int MOVE_CELLS  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int COL_W       = $clog2(SCREEN_COLS);
  localparam int ROW_W       = $clog2(SCREEN_ROWS);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h1F;

  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_READ_CELL  = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_WRITE_AT   = 3'd4;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } ram_wr_t;

  function automatic logic [ADDR_W-1:0] cell_idx(input logic [COL_W-1:0] c,
                                                 input logic [ROW_W-1:0] r);
    cell_idx = ADDR_W'(r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(c);
  endfunction

endpackage

[design/tcc_screen_ram.sv]
// Screen store: one write port, one read port with registered read data.
module tcc_screen_ram (
  input  logic                       clk,
  input  tcc_pkg::ram_wr_t           wr,
  input  logic [tcc_pkg::ADDR_W-1:0] rd_addr,
  output tcc_pkg::cell_t             rd_data
);

  tcc_pkg::cell_t mem [tcc_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[design/text_console_cursor_and_scroll.sv]
// Text console top level: sequencer, cursor registers and screen store.
// Clear and a scrolling put char sweep the store; the store port walks one cell a cycle.
// One word at a time: busy from the accept edge until the strobe cycle; receiver cannot stall.
// Reset (rst, synchronous): cursor to 0, attribute to 0x1F, then a pass
//   blanks every cell with busy high; attribute writes are taken during it.
module text_console_cursor_and_scroll (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op,
  input  logic [7:0]  char_code,
  input  logic [6:0]  pos_x,
  input  logic [4:0]  pos_y,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output logic        busy,
  output logic        done,
  output logic [10:0] cursor_pos,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr
);

  // sequencer states
  localparam logic [2:0] S_INIT   = 3'd0;  // blanking pass after reset
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;  // act on the latched word
  localparam logic [2:0] S_RDWAIT = 3'd3;  // read data lands
  localparam logic [2:0] S_SCROLL = 3'd4;  // move rows up, one cell a cycle
  localparam logic [2:0] S_BLANK  = 3'd5;  // blank cells up to the end of the store
  localparam logic [2:0] S_FINISH = 3'd6;  // drive the result

  localparam logic [tcc_pkg::ADDR_W-1:0] LAST_CELL  =
    tcc_pkg::ADDR_W'(tcc_pkg::CELL_COUNT - 1);
  localparam logic [tcc_pkg::ADDR_W-1:0] MOVE_END   =
    tcc_pkg::ADDR_W'(tcc_pkg::MOVE_CELLS);
  localparam logic [tcc_pkg::ADDR_W-1:0] ROW_STRIDE =
    tcc_pkg::ADDR_W'(tcc_pkg::SCREEN_COLS);
  localparam logic [tcc_pkg::COL_W-1:0]  LAST_COL   =
    tcc_pkg::COL_W'(tcc_pkg::SCREEN_COLS - 1);
  localparam logic [tcc_pkg::ROW_W-1:0]  LAST_ROW   =
    tcc_pkg::ROW_W'(tcc_pkg::SCREEN_ROWS - 1);

  logic [2:0]                 state;
  logic [tcc_pkg::ADDR_W-1:0] cnt;       // sweep address (destination cell)
  logic [tcc_pkg::ADDR_W-1:0] wa;        // destination of the cell in flight
  logic                       pend;      // a moved cell awaits its write
  logic [2:0]                 op_q;
  logic [7:0]                 ch_q;
  logic [tcc_pkg::COL_W-1:0]  x_q;
  logic [tcc_pkg::ROW_W-1:0]  y_q;
  logic [tcc_pkg::COL_W-1:0]  col;
  logic [tcc_pkg::ROW_W-1:0]  row;
  logic [7:0]                 rc_q;
  logic [7:0]                 ra_q;
  logic [7:0]                 attr_reg;

  logic [tcc_pkg::COL_W-1:0]  bs_col;
  logic [tcc_pkg::ROW_W-1:0]  bs_row;
  logic [tcc_pkg::COL_W-1:0]  idx_col;
  logic [tcc_pkg::ROW_W-1:0]  idx_row;
  logic [tcc_pkg::ADDR_W-1:0] idx;
  logic [tcc_pkg::ADDR_W-1:0] rd_addr;
  tcc_pkg::ram_wr_t           wr;
  tcc_pkg::cell_t             rd_data;

  assign busy = (state != S_IDLE);

  // cursor after a backspace: steps back across the row edge, stays at top-left
  always_comb begin
    bs_col = col;
    bs_row = row;
    if (col != '0) begin
      bs_col = col - tcc_pkg::COL_W'(1);
    end else if (row != '0) begin
      bs_col = LAST_COL;
      bs_row = row - tcc_pkg::ROW_W'(1);
    end
  end

  // one index unit shared by the single-cell accesses of a word (put char, write at, read cell)
  always_comb begin
    idx_col = x_q;
    idx_row = y_q;
    if (op_q == tcc_pkg::OP_PUT_CHAR) begin
      if (ch_q == tcc_pkg::CH_BACKSPACE) begin
        idx_col = bs_col;
        idx_row = bs_row;
      end else begin
        idx_col = col;
        idx_row = row;
      end
    end
  end

  assign idx = tcc_pkg::cell_idx(idx_col, idx_row);

  // store port control
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = idx;
    wr.data = '{attr: attr_reg, ch: tcc_pkg::CH_SPACE};
    rd_addr = idx;
    unique case (state)
      S_DECODE: begin
        if (op_q == tcc_pkg::OP_PUT_CHAR) begin
          wr.en = (ch_q != tcc_pkg::CH_NEWLINE);
          if (ch_q != tcc_pkg::CH_BACKSPACE) begin
            wr.data.ch = ch_q;
          end
        end else if (op_q == tcc_pkg::OP_WRITE_AT) begin
          wr.en      = 1'b1;
          wr.data.ch = ch_q;
        end
      end
      S_SCROLL: begin
        rd_addr = cnt + ROW_STRIDE;
        wr.en   = pend;
        wr.addr = wa;
        wr.data = rd_data;
      end
      S_BLANK: begin
        wr.en   = 1'b1;
        wr.addr = cnt;
      end
      S_INIT: begin
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = '{attr: tcc_pkg::ATTR_RESET, ch: tcc_pkg::CH_SPACE};
      end
      default: begin
      end
    endcase
  end

  tcc_screen_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr_reg <= tcc_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr_reg <= cfg_data;
    end
  end

  // word latch, clamped coordinates
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q <= op;
      ch_q <= char_code;
      x_q  <= (int'(pos_x) > tcc_pkg::SCREEN_COLS - 1) ? LAST_COL
                                                        : tcc_pkg::COL_W'(pos_x);
      y_q  <= (int'(pos_y) > tcc_pkg::SCREEN_ROWS - 1) ? LAST_ROW
                                                        : tcc_pkg::ROW_W'(pos_y);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      rc_q <= '0;
      ra_q <= '0;
    end else if (state == S_RDWAIT) begin
      rc_q <= rd_data.ch;
      ra_q <= rd_data.attr;
    end
    if (state == S_FINISH) begin
      cursor_pos <= 11'(tcc_pkg::cell_idx(col, row));
      cell_char  <= rc_q;
      cell_attr  <= ra_q;
    end
  end

  // scroll pipeline: each source cell is read in the cycle before its write
  always_ff @(posedge clk) begin
    if (state == S_SCROLL) begin
      wa <= cnt;
    end
  end

  // sequencer and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      pend  <= 1'b0;
      col   <= '0;
      row   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          if (cnt == LAST_CELL) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + tcc_pkg::ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_FINISH;
          unique case (op_q)
            tcc_pkg::OP_PUT_CHAR: begin
              if (ch_q == tcc_pkg::CH_BACKSPACE) begin
                col <= bs_col;
                row <= bs_row;
              end else if (ch_q == tcc_pkg::CH_NEWLINE || col == LAST_COL) begin
                col <= '0;
                if (row == LAST_ROW) begin
                  cnt   <= '0;
                  pend  <= 1'b0;
                  state <= S_SCROLL;
                end else begin
                  row <= row + tcc_pkg::ROW_W'(1);
                end
              end else begin
                col <= col + tcc_pkg::COL_W'(1);
              end
            end
            tcc_pkg::OP_SET_CURSOR: begin
              col <= x_q;
              row <= y_q;
            end
            tcc_pkg::OP_READ_CELL: begin
              state <= S_RDWAIT;
            end
            tcc_pkg::OP_CLEAR: begin
              col   <= '0;
              row   <= '0;
              cnt   <= '0;
              state <= S_BLANK;
            end
            default: begin
            end
          endcase
        end
        S_RDWAIT: begin
          state <= S_FINISH;
        end
        S_SCROLL: begin
          if (cnt != MOVE_END) begin
            pend <= 1'b1;
            cnt  <= cnt + tcc_pkg::ADDR_W'(1);
          end else begin
            // last moved cell written this cycle; cnt now opens the bottom row
            pend  <= 1'b0;
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (cnt == LAST_CELL) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + tcc_pkg::ADDR_W'(1);
          end
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
